@@ design/smt_pkg.sv @@
// ----------------------------------------------------------------------------
// smt_pkg: shared definitions for the sorted multiset table
// Capacity, field widths, request codes and the control word that the
// controller broadcasts to every cell of the chain.
// ----------------------------------------------------------------------------
package smt_pkg;

   localparam int CAPACITY    = 32;
   localparam int DATA_W      = 32;
   localparam int CNT_W       = $clog2(CAPACITY + 1);
   localparam int COUNT_OUT_W = 6;
   localparam int REQ_W       = 2;

   // Request codes carried on req_tuser
   localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
   localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
   localparam logic [REQ_W-1:0] REQ_DUMP   = 2'd2;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE,
      CELL_ROTATE
   } cell_op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DUMP,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      cell_op_type              op;
      logic signed [DATA_W-1:0] x;
   } cell_ctrl_type;

endpackage

@@ design/smt_cell.sv @@
// ----------------------------------------------------------------------------
// smt_cell: one slot of the sorted chain
// Holds one value and its valid bit. Compares against the broadcast operand
// and takes its next value from itself, the operand, a neighbor or the head cell.
// ----------------------------------------------------------------------------
module smt_cell
   import smt_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  cell_ctrl_type            ctrl,
   input  logic signed [DATA_W-1:0] head_value,
   input  logic signed [DATA_W-1:0] left_value,
   input  logic                     left_valid,
   input  logic                     left_less,
   input  logic signed [DATA_W-1:0] right_value,
   input  logic                     right_valid,
   input  logic                     hit_in,
   output logic signed [DATA_W-1:0] value,
   output logic                     valid,
   output logic                     less,
   output logic                     hit_out
);

   logic signed [DATA_W-1:0] value_ff, value_in;
   logic                     valid_ff, valid_in;
   logic                     match;

   // Compare the stored entry with the operand
   assign less    = valid_ff && (value_ff < ctrl.x);
   assign match   = valid_ff && (value_ff == ctrl.x);
   assign hit_out = hit_in | match;
   assign value   = value_ff;
   assign valid   = valid_ff;

   // Select the next entry
   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      unique case (ctrl.op)
         CELL_INSERT: begin
            // keep smaller entries, open the gap, shift the rest right
            if (!less) begin
               value_in = left_less ? ctrl.x : left_value;
               valid_in = valid_ff | left_valid;
            end
         end
         CELL_DELETE: begin
            // close the gap from the first match onward
            if (hit_out) begin
               value_in = right_value;
               valid_in = right_valid;
            end
         end
         CELL_ROTATE: begin
            // rotate the filled region left by one
            value_in = right_valid ? right_value : head_value;
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule

@@ design/sorted_multiset_table_core.sv @@
// Insert, delete, unknown codes and an empty-table dump: result registered on
//   the transfer; one such item per cycle while the result side keeps up.
// Dump: the chain rotates past cell 0 once per stored entry and each held
//   value is emitted when a different one reaches cell 0; then the block leaves
//   the rotation and emits the final result. No request is taken meanwhile.
// Reset clears the entry count and all cell valid bits; no clearing pass.
// ----------------------------------------------------------------------------
// sorted_multiset_table_core: ordered multiset of signed values
// A chain of cells keeps the entries sorted; inserts and deletes shift the
// chain in parallel, a dump rotates it and emits each distinct value.
// ----------------------------------------------------------------------------
module sorted_multiset_table_core
   import smt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [31:0]         req_tdata,  // [31:0] value
   input  logic [REQ_W-1:0]    req_tuser,  // [1:0] req_type
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [39:0]         rsp_tdata,  // [31:0] out_value, [37:32] entry_count, pad
   output logic [2:0]          rsp_tuser,  // [0] found, [1] dropped, [2] has_value
   output logic                rsp_tlast   // last
);

   cell_ctrl_type            ctrl;
   logic signed [DATA_W-1:0] cell_value [CAPACITY];
   logic                     cell_valid [CAPACITY];
   logic                     cell_less  [CAPACITY];
   logic                     cell_hit   [CAPACITY];
   logic signed [DATA_W-1:0] head_value;
   logic                     found_any;

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         step_ff, step_in;
   logic                     pend_valid_ff, pend_valid_in;
   logic signed [DATA_W-1:0] pend_value_ff, pend_value_in;

   logic                     rsp_valid_ff;
   logic signed [DATA_W-1:0] out_value_ff, out_value_in;
   logic [CNT_W-1:0]         out_count_ff, out_count_in;
   logic                     out_found_ff, out_found_in;
   logic                     out_dropped_ff, out_dropped_in;
   logic                     out_has_ff, out_has_in;
   logic                     out_last_ff, out_last_in;
   logic                     load;
   logic                     out_free;
   logic                     distinct;

   assign head_value = cell_value[0];
   assign found_any  = cell_hit[CAPACITY-1];
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Chain of cells with neighbor links
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [DATA_W-1:0] lv, rv;
      logic                     lvld, lless, rvld, hin;
      if (i == 0) begin : g_first
         assign lv    = ctrl.x;
         assign lvld  = 1'b1;
         assign lless = 1'b1;
         assign hin   = 1'b0;
      end else begin : g_mid
         assign lv    = cell_value[i-1];
         assign lvld  = cell_valid[i-1];
         assign lless = cell_less[i-1];
         assign hin   = cell_hit[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign rv   = head_value;
         assign rvld = 1'b0;
      end else begin : g_inner
         assign rv   = cell_value[i+1];
         assign rvld = cell_valid[i+1];
      end
      smt_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .head_value  (head_value),
         .left_value  (lv),
         .left_valid  (lvld),
         .left_less   (lless),
         .right_value (rv),
         .right_valid (rvld),
         .hit_in      (hin),
         .value       (cell_value[i]),
         .valid       (cell_valid[i]),
         .less        (cell_less[i]),
         .hit_out     (cell_hit[i])
      );
   end

   // Sequence requests, drive the chain and fill the result register
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      step_in        = step_ff;
      pend_valid_in  = pend_valid_ff;
      pend_value_in  = pend_value_ff;
      ctrl.op        = CELL_HOLD;
      ctrl.x         = $signed(req_tdata);
      load           = 1'b0;
      out_value_in   = '0;
      out_count_in   = count_ff;
      out_found_in   = 1'b0;
      out_dropped_in = 1'b0;
      out_has_in     = 1'b0;
      out_last_in    = 1'b1;
      req_tready     = 1'b0;
      distinct       = !pend_valid_ff || (head_value != pend_value_ff);
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = out_free;
            if (req_tvalid && out_free) begin
               load = 1'b1;
               unique case (req_tuser)
                  REQ_INSERT: begin
                     if (count_ff < CNT_W'(CAPACITY)) begin
                        ctrl.op  = CELL_INSERT;
                        count_in = count_ff + CNT_W'(1);
                     end else begin
                        out_dropped_in = 1'b1;
                     end
                  end
                  REQ_DELETE: begin
                     ctrl.op = CELL_DELETE;
                     if (found_any) begin
                        count_in     = count_ff - CNT_W'(1);
                        out_found_in = 1'b1;
                     end
                  end
                  REQ_DUMP: begin
                     if (count_ff != '0) begin
                        load          = 1'b0;
                        state_in      = ST_DUMP;
                        step_in       = '0;
                        pend_valid_in = 1'b0;
                     end
                  end
                  default: begin
                     load = 1'b1;
                  end
               endcase
               out_count_in = count_in;
            end
         end
         ST_DUMP: begin
            if (step_ff == count_ff) begin
               state_in = ST_FLUSH;
            end else if (distinct && pend_valid_ff) begin
               // emit the held value once a new one shows up
               if (out_free) begin
                  load          = 1'b1;
                  out_value_in  = pend_value_ff;
                  out_has_in    = 1'b1;
                  out_last_in   = 1'b0;
                  ctrl.op       = CELL_ROTATE;
                  pend_value_in = head_value;
                  step_in       = step_ff + CNT_W'(1);
               end
            end else begin
               ctrl.op       = CELL_ROTATE;
               pend_valid_in = 1'b1;
               pend_value_in = head_value;
               step_in       = step_ff + CNT_W'(1);
            end
         end
         ST_FLUSH: begin
            // emit the largest value as the final result
            if (out_free) begin
               load         = 1'b1;
               out_value_in = pend_value_ff;
               out_has_in   = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         step_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         step_ff       <= step_in;
         pend_valid_ff <= pend_valid_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Hold the result payload until its transfer
   always_ff @(posedge clock) begin
      pend_value_ff <= pend_value_in;
      if (load) begin
         out_value_ff   <= out_value_in;
         out_count_ff   <= out_count_in;
         out_found_ff   <= out_found_in;
         out_dropped_ff <= out_dropped_in;
         out_has_ff     <= out_has_in;
         out_last_ff    <= out_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, COUNT_OUT_W'(out_count_ff), out_value_ff};
   assign rsp_tuser  = {out_has_ff, out_dropped_ff, out_found_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

@@ dv/tb_sorted_multiset_table_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_multiset_table_core: self-checking bench for the sorted table
// Drives insert, delete, dump and unused requests over the request stream.
// Tracks the table contents in a sorted queue and checks every response
// field against it. A short table of directed requests runs first, then
// a fill to capacity, then random blocks that alternate filling, draining
// and mixed traffic. Both stream sides idle at random. One block holds the
// response side off long enough to back up the request side.
// ----------------------------------------------------------------------------
module tb_sorted_multiset_table_core;
   import smt_pkg::*;

   localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

   localparam int ITEMS_TOTAL     = 480;
   localparam int BLOCK_ITEMS     = 40;
   localparam int PRESSURE_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 2 * CAPACITY + 8;
   localparam int MAX_PRINTS      = 100;
   localparam longint LIMIT_NS    = 64'd5_000_000;

   typedef enum logic {
      CHK_MODEL,
      CHK_FIXED
   } chk_kind_type;

   typedef enum logic [1:0] {
      PH_FILL,
      PH_DRAIN,
      PH_MIX
   } phase_type;

   // One response as the bench sees it, fields unpacked from the streams
   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic [COUNT_OUT_W-1:0]   count;
      logic                     found;
      logic                     dropped;
      logic                     has_value;
      logic                     last;
   } rsp_item_type;

   // Directed request; the fixed columns are used only for CHK_FIXED rows
   typedef struct packed {
      logic [REQ_W-1:0]       op;
      logic [DATA_W-1:0]      value;
      chk_kind_type           chk;
      logic [COUNT_OUT_W-1:0] cnt;
      logic                   fnd;
      logic                   drp;
   } dir_row_type;

   localparam int DIR_ROWS = 22;
   localparam dir_row_type DIR_TAB [DIR_ROWS] = '{
      '{REQ_DUMP,   32'h0000_0000, CHK_FIXED, 6'd0, 1'b0, 1'b0},
      '{REQ_DELETE, 32'h0000_0000, CHK_FIXED, 6'd0, 1'b0, 1'b0},
      '{REQ_UNUSED, 32'hFFFF_FFFF, CHK_FIXED, 6'd0, 1'b0, 1'b0},
      '{REQ_INSERT, 32'h7FFF_FFFF, CHK_FIXED, 6'd1, 1'b0, 1'b0},
      '{REQ_INSERT, 32'h8000_0000, CHK_FIXED, 6'd2, 1'b0, 1'b0},
      '{REQ_INSERT, 32'h0000_0000, CHK_FIXED, 6'd3, 1'b0, 1'b0},
      '{REQ_INSERT, 32'hFFFF_FFFF, CHK_FIXED, 6'd4, 1'b0, 1'b0},
      '{REQ_INSERT, 32'h0000_0001, CHK_FIXED, 6'd5, 1'b0, 1'b0},
      '{REQ_INSERT, 32'h0000_0000, CHK_FIXED, 6'd6, 1'b0, 1'b0},
      '{REQ_INSERT, 32'h7FFF_FFFF, CHK_FIXED, 6'd7, 1'b0, 1'b0},
      '{REQ_DUMP,   32'h0000_0000, CHK_MODEL, 6'd0, 1'b0, 1'b0},
      '{REQ_DELETE, 32'h0000_0005, CHK_FIXED, 6'd7, 1'b0, 1'b0},
      '{REQ_DELETE, 32'h0000_0000, CHK_FIXED, 6'd6, 1'b1, 1'b0},
      '{REQ_DELETE, 32'h7FFF_FFFF, CHK_FIXED, 6'd5, 1'b1, 1'b0},
      '{REQ_UNUSED, 32'h5555_5555, CHK_FIXED, 6'd5, 1'b0, 1'b0},
      '{REQ_DUMP,   32'h0000_0000, CHK_MODEL, 6'd0, 1'b0, 1'b0},
      '{REQ_INSERT, 32'hAAAA_AAAA, CHK_MODEL, 6'd0, 1'b0, 1'b0},
      '{REQ_INSERT, 32'h5555_5555, CHK_MODEL, 6'd0, 1'b0, 1'b0},
      '{REQ_DELETE, 32'h8000_0000, CHK_MODEL, 6'd0, 1'b0, 1'b0},
      '{REQ_DELETE, 32'h8000_0000, CHK_MODEL, 6'd0, 1'b0, 1'b0},
      '{REQ_DUMP,   32'h0000_0000, CHK_MODEL, 6'd0, 1'b0, 1'b0},
      '{REQ_DUMP,   32'hFFFF_FFFF, CHK_MODEL, 6'd0, 1'b0, 1'b0}
   };

   // Values that collide often, extremes included
   localparam logic [DATA_W-1:0] VALUE_POOL [8] = '{
      32'h8000_0000, 32'h8000_0001, 32'hFFFF_FFFF, 32'h0000_0000,
      32'h0000_0001, 32'h0000_0002, 32'h7FFF_FFFE, 32'h7FFF_FFFF
   };

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [31:0]            req_tdata  = '0;  // [31:0] value
   logic [REQ_W-1:0]       req_tuser  = '0;  // [1:0] req_type
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [39:0]            rsp_tdata;        // [31:0] out_value, [37:32] entry_count
   logic [2:0]             rsp_tuser;        // [0] found, [1] dropped, [2] has_value
   logic                   rsp_tlast;

   // Table contents as they should be, kept sorted ascending
   logic signed [DATA_W-1:0] table_vals [$];
   rsp_item_type             pending_rsp [$];

   int  err_count     = 0;
   int  sent_count    = 0;
   int  rsp_count     = 0;
   bit  send_no_idle  = 1'b0;
   bit  recv_no_idle  = 1'b0;
   bit  pressure_req  = 1'b0;

   sorted_multiset_table_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // Free-running clock, 2 ns period
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Hold reset from the start, then release it for good
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   end

   // Hard stop in case the handshakes hang
   initial begin
      #(LIMIT_NS);
      $display("Simulation FAILED");
      $finish;
   end

   task automatic flag_error(input string msg);
      if (err_count < MAX_PRINTS)
         $display("ERROR @%0t: %s", $realtime, msg);
      err_count++;
   endtask

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50)
         return 0;
      else if (r < 85)
         return $urandom_range(1, 3);
      else if (r < 95)
         return $urandom_range(4, 10);
      else
         return $urandom_range(20, 40);
   endfunction

   // Apply one request to the tracked table; record its responses if asked
   function automatic void table_update(input logic [REQ_W-1:0] op,
                                        input logic signed [DATA_W-1:0] val,
                                        input bit record);
      rsp_item_type r;
      int           p;
      bit           hit;
      r   = '0;
      hit = 1'b0;
      case (op)
         REQ_INSERT: begin
            if (table_vals.size() >= CAPACITY) begin
               r.dropped = 1'b1;
            end else begin
               p = 0;
               while (p < table_vals.size() && table_vals[p] < val)
                  p++;
               table_vals.insert(p, val);
            end
         end
         REQ_DELETE: begin
            for (p = 0; p < table_vals.size() && !hit; p++) begin
               if (table_vals[p] == val) begin
                  table_vals.delete(p);
                  hit = 1'b1;
               end
            end
            r.found = hit;
         end
         REQ_DUMP: begin
            // one response per distinct value, last marked on the final one
            for (p = 0; p < table_vals.size(); p++) begin
               if (p == 0 || table_vals[p] != table_vals[p-1]) begin
                  if (hit && record)
                     pending_rsp.push_back(r);
                  r           = '0;
                  r.value     = table_vals[p];
                  r.count     = COUNT_OUT_W'(table_vals.size());
                  r.has_value = 1'b1;
                  hit         = 1'b1;
               end
            end
         end
         default: ;
      endcase
      r.count = COUNT_OUT_W'(table_vals.size());
      r.last  = 1'b1;
      if (record)
         pending_rsp.push_back(r);
   endfunction

   // Offer one request, hold it until the transfer, then predict
   task automatic send_request(input logic [REQ_W-1:0] op,
                               input logic [DATA_W-1:0] val,
                               input bit use_fixed,
                               input rsp_item_type fixed_rsp);
      int gap;
      gap = send_no_idle ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= val;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      table_update(op, val, !use_fixed);
      if (use_fixed)
         pending_rsp.push_back(fixed_rsp);
      sent_count++;
   endtask

   function automatic logic [DATA_W-1:0] pick_value(input logic [REQ_W-1:0] op);
      int r;
      r = $urandom_range(0, 99);
      if (op == REQ_DELETE && table_vals.size() > 0 && r < 50)
         return table_vals[$urandom_range(0, table_vals.size() - 1)];
      else if (r < 75)
         return VALUE_POOL[$urandom_range(0, 7)];
      else
         return $urandom;
   endfunction

   // Draw one request with the mix of the current phase
   task automatic random_request(input phase_type ph);
      int               r;
      int               ins_w;
      int               del_w;
      logic [REQ_W-1:0] op;
      case (ph)
         PH_FILL:  begin ins_w = 70; del_w = 15; end
         PH_DRAIN: begin ins_w = 15; del_w = 70; end
         default:  begin ins_w = 42; del_w = 40; end
      endcase
      r = $urandom_range(0, 99);
      if (r < ins_w)
         op = REQ_INSERT;
      else if (r < ins_w + del_w)
         op = REQ_DELETE;
      else if (r < 95)
         op = REQ_DUMP;
      else
         op = REQ_UNUSED;
      send_request(op, pick_value(op), 1'b0, '0);
   endtask

   // Response side: random ready pattern, one long hold-off on request
   initial begin : rsp_drive
      int run_len;
      int stall;
      wait (!reset);
      forever begin
         if (pressure_req) begin
            rsp_tready <= 1'b0;
            repeat (PRESSURE_CYCLES) @(posedge clock);
            pressure_req = 1'b0;
         end else if (recv_no_idle) begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end else begin
            run_len = $urandom_range(1, 8);
            rsp_tready <= 1'b1;
            repeat (run_len) @(posedge clock);
            stall = pick_gap();
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
      end
   end

   // Compare each response transfer with the oldest prediction
   always @(posedge clock) begin : rsp_check
      rsp_item_type got;
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.value     = rsp_tdata[31:0];
         got.count     = rsp_tdata[37:32];
         got.found     = rsp_tuser[0];
         got.dropped   = rsp_tuser[1];
         got.has_value = rsp_tuser[2];
         got.last      = rsp_tlast;
         if (pending_rsp.size() == 0) begin
            flag_error($sformatf("response %0d arrived with none expected", rsp_count));
         end else begin
            want = pending_rsp.pop_front();
            if (got.value !== want.value)
               flag_error($sformatf("response %0d out_value %0d, expected %0d",
                                    rsp_count, got.value, want.value));
            if (got.count !== want.count)
               flag_error($sformatf("response %0d entry_count %0d, expected %0d",
                                    rsp_count, got.count, want.count));
            if (got.found !== want.found)
               flag_error($sformatf("response %0d found %b, expected %b",
                                    rsp_count, got.found, want.found));
            if (got.dropped !== want.dropped)
               flag_error($sformatf("response %0d dropped %b, expected %b",
                                    rsp_count, got.dropped, want.dropped));
            if (got.has_value !== want.has_value)
               flag_error($sformatf("response %0d has_value %b, expected %b",
                                    rsp_count, got.has_value, want.has_value));
            if (got.last !== want.last)
               flag_error($sformatf("response %0d last %b, expected %b",
                                    rsp_count, got.last, want.last));
         end
         rsp_count++;
      end
   end

   // Request side: directed table, fill to capacity, then random blocks
   initial begin : stimulus
      dir_row_type  row;
      rsp_item_type fixed;
      int           blk;
      int           n;
      phase_type    ph;
      wait (!reset);
      @(posedge clock);

      // walk the directed table
      for (int i = 0; i < DIR_ROWS; i++) begin
         row             = DIR_TAB[i];
         fixed           = '0;
         fixed.count     = row.cnt;
         fixed.found     = row.fnd;
         fixed.dropped   = row.drp;
         fixed.last      = 1'b1;
         send_request(row.op, row.value, row.chk == CHK_FIXED, fixed);
      end

      // fill the table, push past full, dump it whole
      while (table_vals.size() < CAPACITY)
         send_request(REQ_INSERT, pick_value(REQ_INSERT), 1'b0, '0);
      repeat (3) send_request(REQ_INSERT, pick_value(REQ_INSERT), 1'b0, '0);
      send_request(REQ_DUMP, $urandom, 1'b0, '0);
      send_request(REQ_UNUSED, $urandom, 1'b0, '0);

      // random blocks; block 1 backs up the request side, block 4 never idles
      blk = 0;
      while (sent_count < ITEMS_TOTAL) begin
         case (blk % 4)
            0:       ph = PH_DRAIN;
            2:       ph = PH_FILL;
            default: ph = PH_MIX;
         endcase
         if (blk == 1) begin
            pressure_req = 1'b1;
            send_no_idle = 1'b1;
         end
         if (blk == 4) begin
            send_no_idle = 1'b1;
            recv_no_idle = 1'b1;
         end
         for (n = 0; n < BLOCK_ITEMS && sent_count < ITEMS_TOTAL; n++)
            random_request(ph);
         send_no_idle = 1'b0;
         recv_no_idle = 1'b0;
         blk++;
      end
      req_tvalid <= 1'b0;

      // let the last responses drain, then a quiet tail
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (err_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
